[sv/nsc_pkg.sv]
package nsc_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] HexTen     = 8'd10;

  localparam int unsigned NumTypes = 5;
  localparam logic [2:0]  HdrLen   = 3'd5;
  localparam logic [2:0]  HdrSat   = 3'd7;
  localparam logic [3:0]  FieldSat = 4'd15;

  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeBody = 4'b0010,
    ModeHi   = 4'b0100,
    ModeLo   = 4'b1000
  } mode_e;

  typedef enum logic [3:0] {
    EvIdle    = 4'd0,
    EvHeader  = 4'd1,
    EvField   = 4'd2,
    EvDelim   = 4'd3,
    EvDigit   = 4'd4,
    EvOk      = 4'd5,
    EvBadCks  = 4'd6,
    EvUnknown = 4'd7,
    EvNoCks   = 4'd8
  } event_e;

  typedef enum logic [2:0] {
    TypeUnknown = 3'd0,
    TypeHchdg   = 3'd1,
    TypeWimwv   = 3'd2,
    TypeGpvtg   = 3'd3,
    TypeGpgll   = 3'd4,
    TypeGprmc   = 3'd5
  } sent_e;

  typedef struct packed {
    mode_e                 mode;
    logic [7:0]            xr;
    logic [NumTypes-1:0]   match;
    logic [2:0]            pos;
    logic [3:0]            fields;
    logic [7:0]            hi;
  } state_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [3:0] field_index;
    event_e     event_res;
    sent_e      sentence_type;
    logic [3:0] expected_fields;
  } res_t;

  localparam state_t StateReset = '{
    mode:   ModeIdle,
    xr:     8'h00,
    match:  {NumTypes{1'b1}},
    pos:    3'd0,
    fields: 4'd0,
    hi:     8'h00
  };

  // bit k: type k+1 has character c at header position pos
  function automatic logic [NumTypes-1:0] hdr_hits(logic [2:0] pos, logic [7:0] c);
    logic [NumTypes-1:0] h;
    h = '0;
    case (pos)
      3'd0: h = {c == "G", c == "G", c == "G", c == "W", c == "H"};
      3'd1: h = {c == "P", c == "P", c == "P", c == "I", c == "C"};
      3'd2: h = {c == "R", c == "G", c == "V", c == "M", c == "H"};
      3'd3: h = {c == "M", c == "L", c == "T", c == "W", c == "D"};
      3'd4: h = {c == "C", c == "L", c == "G", c == "V", c == "G"};
      default: h = '0;
    endcase
    return h;
  endfunction

  function automatic sent_e cur_type(logic [2:0] pos, logic [NumTypes-1:0] match);
    sent_e t;
    t = TypeUnknown;
    if (pos == HdrLen) begin
      if (match[0]) t = TypeHchdg;
      else if (match[1]) t = TypeWimwv;
      else if (match[2]) t = TypeGpvtg;
      else if (match[3]) t = TypeGpgll;
      else if (match[4]) t = TypeGprmc;
    end
    return t;
  endfunction

  function automatic logic [3:0] type_fields(sent_e t);
    logic [3:0] n;
    case (t)
      TypeHchdg: n = 4'd5;
      TypeWimwv: n = 4'd5;
      TypeGpvtg: n = 4'd9;
      TypeGpgll: n = 4'd7;
      TypeGprmc: n = 4'd12;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (c >= CharUpperA) v = c - CharUpperA + HexTen;
    else v = c - CharZero;
    return v;
  endfunction

endpackage

[sv/nmea_sentence_checker.sv]
// NMEA 0183 sentence checker.
// Input channel: one ASCII character per request on char_in_i, with
// in_valid_i / in_ready_o. Output channel: one result per character on
// char_out_o, field_index_o, event_res_o, sentence_type_o and
// expected_fields_o, with out_valid_o / out_ready_i.
// A character is captured in an input register; the parser then updates the
// sentence state and loads the result register as soon as that register is
// empty or its result is taken, and the result is shown from that register.
// One character per cycle is sustained while the receiver takes every result;
// the single path from input register through the parser to the result
// register sets that figure.
// When the receiver stalls, the result register holds and the input register
// still takes one more character; after that in_ready_o drops until the
// result is taken. The sentence state only advances when a character moves
// into the result register.
// Reset empties both registers and puts the parser in idle, waiting for '$'.
module nmea_sentence_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic [3:0] field_index_o,
  output logic [3:0] event_res_o,
  output logic [2:0] sentence_type_o,
  output logic [3:0] expected_fields_o
);

  logic            in_vld_q;
  logic [7:0]      char_q;
  logic            out_vld_q;
  nsc_pkg::res_t   res_q;
  nsc_pkg::res_t   res_d;
  nsc_pkg::state_t state_q;
  nsc_pkg::state_t state_d;
  logic            adv;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  nsc_parse u_parse (
    .cur_i  (state_q),
    .char_i (char_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= nsc_pkg::StateReset;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) char_q <= char_in_i;
    if (adv) res_q <= res_d;
  end

  assign out_valid_o       = out_vld_q;
  assign char_out_o        = res_q.char_out;
  assign field_index_o     = res_q.field_index;
  assign event_res_o       = res_q.event_res;
  assign sentence_type_o   = res_q.sentence_type;
  assign expected_fields_o = res_q.expected_fields;

endmodule

[sv/nsc_parse.sv]
module nsc_parse (
  input  nsc_pkg::state_t cur_i,
  input  logic [7:0]      char_i,
  output nsc_pkg::state_t nxt_o,
  output nsc_pkg::res_t   res_o
);

  nsc_pkg::state_t nxt;
  nsc_pkg::event_e ev;
  nsc_pkg::sent_e  typ;
  nsc_pkg::sent_e  typ_cur;
  logic            report;
  logic [7:0]      sum;

  assign typ_cur = nsc_pkg::cur_type(cur_i.pos, cur_i.match);
  assign sum     = {cur_i.hi[3:0], 4'b0000} + nsc_pkg::hex_value(char_i);

  always_comb begin
    nxt    = cur_i;
    ev     = nsc_pkg::EvIdle;
    report = 1'b1;
    if (char_i == nsc_pkg::CharDollar) begin
      nxt      = nsc_pkg::StateReset;
      nxt.mode = nsc_pkg::ModeBody;
      ev       = nsc_pkg::EvHeader;
    end else begin
      case (cur_i.mode)
        nsc_pkg::ModeIdle: begin
          report = 1'b0;
        end
        nsc_pkg::ModeBody: begin
          if (char_i == nsc_pkg::CharCr || char_i == nsc_pkg::CharLf) begin
            ev       = nsc_pkg::EvNoCks;
            nxt.mode = nsc_pkg::ModeIdle;
          end else if (char_i == nsc_pkg::CharStar) begin
            ev       = nsc_pkg::EvDelim;
            nxt.mode = nsc_pkg::ModeHi;
          end else begin
            nxt.xr = cur_i.xr ^ char_i;
            if (char_i == nsc_pkg::CharComma) begin
              if (cur_i.fields != nsc_pkg::FieldSat) nxt.fields = cur_i.fields + 4'd1;
              ev = nsc_pkg::EvDelim;
            end else if (cur_i.fields == 4'd0) begin
              if (cur_i.pos < nsc_pkg::HdrLen) begin
                nxt.match = cur_i.match & nsc_pkg::hdr_hits(cur_i.pos, char_i);
              end else begin
                nxt.match = '0;
              end
              if (cur_i.pos != nsc_pkg::HdrSat) nxt.pos = cur_i.pos + 3'd1;
              ev = nsc_pkg::EvHeader;
            end else begin
              ev = nsc_pkg::EvField;
            end
          end
        end
        nsc_pkg::ModeHi: begin
          nxt.hi   = nsc_pkg::hex_value(char_i);
          nxt.mode = nsc_pkg::ModeLo;
          ev       = nsc_pkg::EvDigit;
        end
        nsc_pkg::ModeLo: begin
          if (sum != cur_i.xr) ev = nsc_pkg::EvBadCks;
          else if (typ_cur == nsc_pkg::TypeUnknown) ev = nsc_pkg::EvUnknown;
          else ev = nsc_pkg::EvOk;
          nxt.mode = nsc_pkg::ModeIdle;
        end
        default: begin
          nxt.mode = nsc_pkg::ModeIdle;
          report   = 1'b0;
        end
      endcase
    end
  end

  assign typ   = report ? nsc_pkg::cur_type(nxt.pos, nxt.match) : nsc_pkg::TypeUnknown;
  assign nxt_o = nxt;

  always_comb begin
    res_o.char_out        = char_i;
    res_o.field_index     = report ? nxt.fields : 4'd0;
    res_o.event_res       = ev;
    res_o.sentence_type   = typ;
    res_o.expected_fields = nsc_pkg::type_fields(typ);
  end

endmodule

[sv/nsc_checker.sv]
module nsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] char_out_o,
  input logic [3:0] field_index_o,
  input logic [3:0] event_res_o,
  input logic [2:0] sentence_type_o,
  input logic [3:0] expected_fields_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_out_o)
      && $stable(event_res_o))
    else $error("result changed while stalled");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == nsc_pkg::EvIdle |->
      field_index_o == 4'd0 && sentence_type_o == nsc_pkg::TypeUnknown)
    else $error("idle result carries sentence data");

  a_unknown_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_type_o == nsc_pkg::TypeUnknown |-> expected_fields_o == 4'd0)
    else $error("field count without a matched type");

  a_dollar_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_out_o == nsc_pkg::CharDollar |->
      event_res_o == nsc_pkg::EvHeader && field_index_o == 4'd0
      && sentence_type_o == nsc_pkg::TypeUnknown)
    else $error("dollar did not restart the sentence");

  a_ok_typed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == nsc_pkg::EvOk |-> sentence_type_o != nsc_pkg::TypeUnknown)
    else $error("ok reported without a known header");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .char_out_o        (char_out_o),
  .field_index_o     (field_index_o),
  .event_res_o       (event_res_o),
  .sentence_type_o   (sentence_type_o),
  .expected_fields_o (expected_fields_o)
);
